/* design/pt_pkg.sv */
// ----------------------------------------------------------------------------
// pt_pkg: shared types and constants for the span table
// Span record, function and status codes, queue entry types.
// ----------------------------------------------------------------------------
package pt_pkg;

    localparam int MAX_SPANS     = 64;
    localparam int POSITION_BITS = 16;
    localparam int IDX_BITS      = $clog2(MAX_SPANS);
    localparam int CNT_BITS      = $clog2(MAX_SPANS + 1);

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_READOUT = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOROOM = 2'd1,
        ST_SPAN  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic        source;
        logic [15:0] start;
        logic [15:0] length;
    } span_t;

    // Classified item handed from front to back
    typedef struct packed {
        func_t       func;
        logic [15:0] position;
        logic [15:0] insert_length;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        span_t       span;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_PLACE,
        S_READ,
        S_READ_WAIT
    } state_t;

endpackage

/* design/piece_table_insert_and_span_readout_top.sv */
// ----------------------------------------------------------------------------
// piece_table_insert_and_span_readout_top: span table with insert and readout
// Queue-style front end feeding the span table engine.
// ----------------------------------------------------------------------------
// An insert is taken, then walks the spans, reading and comparing each, to
// find its position, decides whether it fits, moves each later span up with
// a read and a write, and places one entry, or three when it splits a span.
// A readout streams one span per cycle while pop keeps up, limited by the
// single read port of the span memory. Clear and readout of an empty table
// push their result as soon as they are taken. Original length written
// through the config port only takes effect at the next clear; after reset
// the table is empty.
module piece_table_insert_and_span_readout_top
    import pt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [15:0] position,
    input  logic [15:0] insert_length,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        span_source,
    output logic [15:0] span_start,
    output logic [15:0] span_length,
    output logic        last
);

    logic [15:0] base_len_reg;
    logic        cmd_valid;
    logic        cmd_take;
    cmd_t        cmd;
    res_t        res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_len_reg <= cfg_wdata;
        end
    end

    pt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .func          (func),
        .position      (position),
        .insert_length (insert_length),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take)
    );

    pt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .base_len  (base_len_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign status      = res.status;
    assign span_source = res.span.source;
    assign span_start  = res.span.start;
    assign span_length = res.span.length;
    assign last        = res.last;

endmodule

/* design/pt_front.sv */
// ----------------------------------------------------------------------------
// pt_front: input stage
// Takes items, drops FUNC_NONE items, masks position, queues for the back.
// ----------------------------------------------------------------------------
module pt_front
    import pt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [15:0] position,
    input  logic [15:0] insert_length,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_take
);

    // two-entry queue
    cmd_t        q_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr, rd;
    cmd_t        c;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign rd        = cmd_valid && cmd_take;
    assign wr        = push && !full && (func_t'(func) != FUNC_NONE);

    always_comb
    begin
        c.func          = func_t'(func);
        c.position      = position & 16'((64'd1 << POSITION_BITS) - 1);
        c.insert_length = insert_length;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

endmodule

/* design/pt_back.sv */
// ----------------------------------------------------------------------------
// pt_back: span table engine
// Walks the span memory to locate an insert, shifts the tail up entry by
// entry, and streams spans on readout into a two-entry result queue.
// ----------------------------------------------------------------------------
module pt_back
    import pt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] base_len,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    output logic        empty,
    input  logic        pop,
    output res_t        res
);

    span_t mem [MAX_SPANS];

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [15:0]            fill_reg, fill_next;
    logic [CNT_BITS-1:0]    i_reg, i_next;          // walk / shift index
    logic [CNT_BITS-1:0]    idx_reg, idx_next;      // covering span index
    logic [16:0]            cur_reg, cur_next;      // running text position
    logic [15:0]            off_reg, off_next;
    logic                   found_reg, found_next;
    logic                   split_reg, split_next;
    span_t                  orig_reg, orig_next;

    // memory port
    logic                   rd_en;
    logic [IDX_BITS-1:0]    rd_addr;
    span_t                  rd_data_reg;
    logic                   rd_ok_reg, rd_ok_next;
    logic                   rd_last_reg, rd_last_next;
    logic                   we;
    logic [IDX_BITS-1:0]    wa;
    span_t                  wd;

    // second write port avoided: placement writes one entry a cycle
    logic [1:0]             place_reg, place_next;

    // result queue
    res_t                   rq_reg [2];
    logic                   rwp_reg, rrp_reg;
    logic [1:0]             rcnt_reg;
    logic                   rpush;
    res_t                   rin;
    logic                   rpop;
    logic                   room;

    assign empty = (rcnt_reg == 2'd0);
    assign res   = rq_reg[rrp_reg];
    assign rpop  = pop && !empty;
    // room for one more push, counting a pending readout word
    assign room  = (rcnt_reg == 2'd0) || (rcnt_reg == 2'd1 && !rd_ok_reg)
                   || (rcnt_reg == 2'd1 && rpop && !rd_ok_reg)
                   || (rpop && rcnt_reg == 2'd2 && !rd_ok_reg)
                   || (rpop && rcnt_reg == 2'd1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        i_next       = i_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        off_next     = off_reg;
        found_next   = found_reg;
        split_next   = split_reg;
        orig_next    = orig_reg;
        place_next   = place_reg;
        cmd_take     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = i_reg[IDX_BITS-1:0];
        rd_ok_next   = 1'b0;
        rd_last_next = 1'b0;
        we           = 1'b0;
        wa           = '0;
        wd           = '0;
        rpush        = 1'b0;
        rin          = '0;
        rin.last     = 1'b1;

        // readout word arriving from memory
        if (rd_ok_reg)
        begin
            rpush       = 1'b1;
            rin.status  = ST_SPAN;
            rin.span    = rd_data_reg;
            rin.last    = rd_last_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !rd_ok_reg && (rcnt_reg == 2'd0 ||
                    (rcnt_reg == 2'd1 && rpop)))
                begin
                    cmd_take = 1'b1;
                    cmd_next = cmd;
                    unique case (cmd.func)
                        FUNC_INSERT:
                        begin
                            i_next     = '0;
                            cur_next   = '0;
                            found_next = 1'b0;
                            idx_next   = count_reg;
                            off_next   = '0;
                            state_next = S_SEARCH;
                        end
                        FUNC_READOUT:
                        begin
                            if (count_reg == '0)
                            begin
                                rpush      = 1'b1;
                                rin.status = ST_EMPTY;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_READ;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            fill_next  = '0;
                            rpush      = 1'b1;
                            rin.status = ST_DONE;
                            if (base_len != '0)
                            begin
                                we         = 1'b1;
                                wa         = '0;
                                wd.source  = 1'b0;
                                wd.start   = '0;
                                wd.length  = base_len;
                                count_next = CNT_BITS'(1);
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // per span: issue read, then compare the registered data
                if (!found_reg && i_reg < count_reg && !rd_ok_reg)
                begin
                    rd_en      = 1'b1;
                    rd_ok_next = 1'b0;
                    state_next = S_READ_WAIT;
                end
                else
                begin
                    split_next = found_reg && (off_reg != '0);
                    if ((CNT_BITS+1)'(count_reg)
                        + ((found_reg && off_reg != '0) ? (CNT_BITS+1)'(2)
                                                         : (CNT_BITS+1)'(1))
                        > (CNT_BITS+1)'(MAX_SPANS)
                        || 17'(fill_reg) + 17'(cmd_reg.insert_length) > 17'hFFFF)
                    begin
                        rpush      = 1'b1;
                        rin.status = ST_NOROOM;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // shift tail up by one or two, from the top down
                        i_next     = count_reg;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_READ_WAIT:
            begin
                // rd_data_reg holds mem[i_reg]
                if (cur_reg + 17'(rd_data_reg.length) > 17'(cmd_reg.position))
                begin
                    found_next = 1'b1;
                    idx_next   = i_reg;
                    off_next   = 16'(17'(cmd_reg.position) - cur_reg);
                    orig_next  = rd_data_reg;
                end
                else
                begin
                    cur_next = cur_reg + 17'(rd_data_reg.length);
                    i_next   = i_reg + CNT_BITS'(1);
                end
                state_next = S_SEARCH;
            end
            S_SHIFT:
            begin
                // two-phase per entry: read i-1, then write i-1+gap
                if (i_reg == idx_reg + (split_reg ? CNT_BITS'(1) : CNT_BITS'(0)))
                begin
                    place_next = 2'd0;
                    state_next = S_PLACE;
                end
                else if (place_reg == 2'd0)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_BITS'(i_reg - CNT_BITS'(1));
                    place_next = 2'd1;
                end
                else
                begin
                    we         = 1'b1;
                    wa         = IDX_BITS'(i_reg - CNT_BITS'(1)
                                 + (split_reg ? CNT_BITS'(2) : CNT_BITS'(1)));
                    wd         = rd_data_reg;
                    i_next     = i_reg - CNT_BITS'(1);
                    place_next = 2'd0;
                end
            end
            S_PLACE:
            begin
                if (!split_reg)
                begin
                    we         = 1'b1;
                    wa         = IDX_BITS'(idx_reg);
                    wd.source  = 1'b1;
                    wd.start   = fill_reg;
                    wd.length  = cmd_reg.insert_length;
                    count_next = count_reg + CNT_BITS'(1);
                    fill_next  = fill_reg + cmd_reg.insert_length;
                    rpush      = 1'b1;
                    rin.status = ST_DONE;
                    rin.span   = wd;
                    state_next = S_IDLE;
                end
                else
                begin
                    unique case (place_reg)
                        2'd0:
                        begin
                            we         = 1'b1;
                            wa         = IDX_BITS'(idx_reg);
                            wd         = orig_reg;
                            wd.length  = off_reg;
                            place_next = 2'd1;
                        end
                        2'd1:
                        begin
                            we         = 1'b1;
                            wa         = IDX_BITS'(idx_reg + CNT_BITS'(2));
                            wd         = orig_reg;
                            wd.start   = orig_reg.start + off_reg;
                            wd.length  = orig_reg.length - off_reg;
                            place_next = 2'd2;
                        end
                        default:
                        begin
                            we         = 1'b1;
                            wa         = IDX_BITS'(idx_reg + CNT_BITS'(1));
                            wd.source  = 1'b1;
                            wd.start   = fill_reg;
                            wd.length  = cmd_reg.insert_length;
                            count_next = count_reg + CNT_BITS'(2);
                            fill_next  = fill_reg + cmd_reg.insert_length;
                            rpush      = 1'b1;
                            rin.status = ST_DONE;
                            rin.span   = wd;
                            place_next = 2'd0;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // issue one read a cycle while the result queue keeps up
                if (room)
                begin
                    rd_en        = 1'b1;
                    rd_ok_next   = 1'b1;
                    rd_last_next = (i_reg + CNT_BITS'(1) == count_reg);
                    i_next       = i_reg + CNT_BITS'(1);
                    if (i_reg + CNT_BITS'(1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rpush)
        begin
            rq_reg[rwp_reg] <= rin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= '0;
            count_reg   <= '0;
            fill_reg    <= '0;
            i_reg       <= '0;
            idx_reg     <= '0;
            cur_reg     <= '0;
            off_reg     <= '0;
            found_reg   <= 1'b0;
            split_reg   <= 1'b0;
            orig_reg    <= '0;
            place_reg   <= '0;
            rd_ok_reg   <= 1'b0;
            rd_last_reg <= 1'b0;
            rwp_reg     <= 1'b0;
            rrp_reg     <= 1'b0;
            rcnt_reg    <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
            i_reg       <= i_next;
            idx_reg     <= idx_next;
            cur_reg     <= cur_next;
            off_reg     <= off_next;
            found_reg   <= found_next;
            split_reg   <= split_next;
            orig_reg    <= orig_next;
            place_reg   <= place_next;
            rd_ok_reg   <= rd_ok_next;
            rd_last_reg <= rd_last_next;
            if (rpush)
            begin
                rwp_reg <= ~rwp_reg;
            end
            if (rpop)
            begin
                rrp_reg <= ~rrp_reg;
            end
            rcnt_reg <= rcnt_reg + 2'(rpush) - 2'(rpop);
        end
    end

endmodule
